>>> src/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int unsigned MAX_CHUNKS = 64;
  localparam int unsigned CNT_W      = $clog2(MAX_CHUNKS + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHUNKS);

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE = 2'd2;

  // one chunk table entry
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
    logic        used;
  } entry_t;

  // controller to chain: pop the head, push one entry at the tail
  typedef struct packed {
    logic   pop;
    logic   push;
    entry_t data;
  } chain_ctl_t;

endpackage

>>> src/ffha_if.sv
`timescale 1ns / 1ps
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] request_size;
  logic [31:0] free_address;

  modport source (output valid, op, request_size, free_address, input ready);
  modport sink   (input valid, op, request_size, free_address, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_address;
  logic [1:0]  status;

  modport source (output valid, data_address, status, input ready);
  modport sink   (input valid, data_address, status, output ready);
endinterface

interface ffha_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// Each request walks every chunk in the table (at most 64 chunks).
// Throughput: one request at a time; every entry passes once through the head cell of
// the row, one entry a cycle apart from the push of a split remainder, and the next
// request is taken once the result is queued.
// Reset: table empty, heap end 0, heap_base 0, heap_limit 1048576, header_size 16.
module first_fit_heap_allocator (
  input  logic             clk_i,
  input  logic             rst_ni,
  ffha_req_if.sink         req_i,
  ffha_rsp_if.source       rsp_o,
  ffha_cfg_if.sink         cfg_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_EXTRA = 5'b00100,
    S_TAIL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] base_q, limit_q;
  logic [8:0]  hdr_q;

  logic [ffha_pkg::CNT_W-1:0] rem_q, rem_d, n_q, n_d, count;
  logic        op_q, op_d;
  logic [32:0] need_q, need_d;
  logic [31:0] fa_q, fa_d;
  logic        found_q, found_d;
  logic        mnext_q, mnext_d;
  logic        pend_vld_q, pend_vld_d;
  ffha_pkg::entry_t pend_q, pend_d, extra_q, extra_d, head;
  logic [31:0] heap_end_q, heap_end_d;
  logic [31:0] addr_q, addr_d;
  logic [1:0]  stat_q, stat_d;
  logic        rsp_vld_q, rsp_vld_d;
  logic [31:0] rsp_addr_q, rsp_addr_d;
  logic [1:0]  rsp_stat_q, rsp_stat_d;

  ffha_pkg::chain_ctl_t ctl;

  logic [31:0] hdr_ext, rest, data_addr;
  logic        a_hit, a_split, f_hit, over;
  logic [33:0] grow;

  ffha_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .head_o  (head),
    .count_o (count)
  );

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      limit_q <= 32'd1048576;
      hdr_q   <= 9'd16;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ffha_pkg::CFG_HEAP_BASE:   base_q  <= cfg_i.data;
        ffha_pkg::CFG_HEAP_LIMIT:  limit_q <= cfg_i.data;
        ffha_pkg::CFG_HEADER_SIZE: hdr_q   <= cfg_i.data[8:0];
        default: ;
      endcase
    end
  end

  // per-entry checks on the head of the row
  assign hdr_ext   = {23'd0, hdr_q};
  assign data_addr = base_q + head.start + hdr_ext;
  assign rest      = head.len - need_q[31:0];
  assign a_hit     = !found_q && !head.used && ({1'b0, head.len} >= need_q);
  assign a_split   = a_hit && (rest > hdr_ext) && (n_q < ffha_pkg::CNT_MAX);
  assign f_hit     = !found_q && head.used && (data_addr == fa_q);
  assign grow      = {2'b00, heap_end_q} + {1'b0, need_q};
  assign over      = (grow > {2'b00, limit_q}) || (n_q >= ffha_pkg::CNT_MAX);

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    rem_d      = rem_q;
    n_d        = n_q;
    op_d       = op_q;
    need_d     = need_q;
    fa_d       = fa_q;
    found_d    = found_q;
    mnext_d    = mnext_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    extra_d    = extra_q;
    heap_end_d = heap_end_q;
    addr_d     = addr_q;
    stat_d     = stat_q;
    rsp_vld_d  = rsp_vld_q && !rsp_o.ready;
    rsp_addr_d = rsp_addr_q;
    rsp_stat_d = rsp_stat_q;
    ctl        = '0;

    case (state_q)
      S_IDLE: begin
        // capture a request word
        if (req_i.valid) begin
          rem_d      = count;
          n_d        = count;
          op_d       = req_i.op;
          need_d     = {1'b0, req_i.request_size} + {24'd0, hdr_q};
          fa_d       = req_i.free_address;
          found_d    = 1'b0;
          mnext_d    = 1'b0;
          pend_vld_d = 1'b0;
          state_d    = S_WALK;
        end
      end

      S_WALK: begin
        if (rem_q == '0) begin
          state_d = S_TAIL;
        end else begin
          ctl.pop = 1'b1;
          rem_d   = rem_q - 1'b1;
          if (op_q == ffha_pkg::OP_ALLOC) begin
            // pass entries on, take the first that fits
            ctl.push = 1'b1;
            ctl.data = head;
            if (a_hit) begin
              found_d       = 1'b1;
              addr_d        = data_addr;
              ctl.data.used = 1'b1;
              if (a_split) begin
                ctl.data.len  = need_q[31:0];
                extra_d.start = head.start + need_q[31:0];
                extra_d.len   = rest;
                extra_d.used  = 1'b0;
                state_d       = S_EXTRA;
              end
            end
          end else begin
            // hold one entry back so neighbors can merge into it
            mnext_d = 1'b0;
            if (f_hit) begin
              found_d = 1'b1;
              mnext_d = 1'b1;
              if (pend_vld_q && !pend_q.used) begin
                pend_d.len = pend_q.len + head.len;
              end else begin
                ctl.push   = pend_vld_q;
                ctl.data   = pend_q;
                pend_d     = head;
                pend_d.used = 1'b0;
                pend_vld_d = 1'b1;
              end
            end else if (mnext_q && !head.used) begin
              pend_d.len = pend_q.len + head.len;
            end else begin
              ctl.push   = pend_vld_q;
              ctl.data   = pend_q;
              pend_d     = head;
              pend_vld_d = 1'b1;
            end
          end
        end
      end

      S_EXTRA: begin
        // drop the split remainder in behind its chunk
        ctl.push = 1'b1;
        ctl.data = extra_q;
        state_d  = S_WALK;
      end

      S_TAIL: begin
        state_d = S_DONE;
        if (op_q == ffha_pkg::OP_ALLOC) begin
          if (found_q) begin
            stat_d = ffha_pkg::ST_OK;
          end else if (over) begin
            stat_d = ffha_pkg::ST_NO_SPACE;
            addr_d = '0;
          end else begin
            // append a chunk at the heap end
            ctl.push       = 1'b1;
            ctl.data.start = heap_end_q;
            ctl.data.len   = need_q[31:0];
            ctl.data.used  = 1'b1;
            heap_end_d     = heap_end_q + need_q[31:0];
            addr_d         = base_q + heap_end_q + hdr_ext;
            stat_d         = ffha_pkg::ST_OK;
          end
        end else begin
          ctl.push = pend_vld_q;
          ctl.data = pend_q;
          addr_d   = '0;
          stat_d   = found_q ? ffha_pkg::ST_OK : ffha_pkg::ST_BAD_FREE;
        end
      end

      S_DONE: begin
        // hand the result to the output register once it is free
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d  = 1'b1;
          rsp_addr_d = addr_q;
          rsp_stat_d = stat_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      heap_end_q <= '0;
      rsp_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      found_q    <= 1'b0;
      mnext_q    <= 1'b0;
      rem_q      <= '0;
      n_q        <= '0;
    end else begin
      state_q    <= state_d;
      heap_end_q <= heap_end_d;
      rsp_vld_q  <= rsp_vld_d;
      pend_vld_q <= pend_vld_d;
      found_q    <= found_d;
      mnext_q    <= mnext_d;
      rem_q      <= rem_d;
      n_q        <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    need_q     <= need_d;
    fa_q       <= fa_d;
    pend_q     <= pend_d;
    extra_q    <= extra_d;
    addr_q     <= addr_d;
    stat_q     <= stat_d;
    rsp_addr_q <= rsp_addr_d;
    rsp_stat_q <= rsp_stat_d;
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.data_address = rsp_addr_q;
  assign rsp_o.status       = rsp_stat_q;

  // the row never holds more than its depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= ffha_pkg::CNT_MAX)
    else $error("chunk count above table depth");

  // never pop an empty row
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.pop |-> count != '0)
    else $error("pop from empty chunk row");

  // never push into a full row
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.push && !ctl.pop) |-> count < ffha_pkg::CNT_MAX)
    else $error("push into full chunk row");

  // an accepted request starts the table walk
  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> state_q == S_WALK)
    else $error("accepted request did not start walk");

endmodule

>>> src/ffha_cell.sv
`timescale 1ns / 1ps
module ffha_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  ffha_pkg::entry_t nbr_i,
  input  logic             load_i,
  input  ffha_pkg::entry_t load_data_i,
  output ffha_pkg::entry_t entry_o
);

  ffha_pkg::entry_t entry_q;

  // take a pushed word, else move down from the upper neighbor
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= load_data_i;
    end else if (shift_i) begin
      entry_q <= nbr_i;
    end
  end

  assign entry_o = entry_q;

endmodule

>>> src/ffha_chain.sv
`timescale 1ns / 1ps
module ffha_chain (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ffha_pkg::chain_ctl_t       ctl_i,
  output ffha_pkg::entry_t           head_o,
  output logic [ffha_pkg::CNT_W-1:0] count_o
);

  logic [ffha_pkg::CNT_W-1:0] cnt_q, cnt_d, tail;
  ffha_pkg::entry_t           ent [ffha_pkg::MAX_CHUNKS];

  // slot that takes a pushed word after this cycle's pop
  assign tail = cnt_q - ffha_pkg::CNT_W'(ctl_i.pop);

  for (genvar i = 0; i < ffha_pkg::MAX_CHUNKS; i++) begin : g_cell
    ffha_pkg::entry_t nbr;
    logic             load;
    if (i == ffha_pkg::MAX_CHUNKS - 1) begin : g_last
      assign nbr = ent[i];
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    assign load = ctl_i.push && (tail == ffha_pkg::CNT_W'(i));

    ffha_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (ctl_i.pop),
      .nbr_i       (nbr),
      .load_i      (load),
      .load_data_i (ctl_i.data),
      .entry_o     (ent[i])
    );
  end

  // track the number of entries held in the row
  assign cnt_d = cnt_q + ffha_pkg::CNT_W'(ctl_i.push) - ffha_pkg::CNT_W'(ctl_i.pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = ent[0];
  assign count_o = cnt_q;

endmodule

>>> bench/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;

  localparam int unsigned NCH = ffha_pkg::MAX_CHUNKS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ffha_req_if req_if ();
  ffha_rsp_if rsp_if ();
  ffha_cfg_if cfg_if ();

  first_fit_heap_allocator u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source),
    .cfg_i (cfg_if.sink)
  );

  typedef struct packed {
    logic        op;
    logic [31:0] request_size;
    logic [31:0] free_address;
  } request_t;

  typedef struct packed {
    logic [31:0] data_address;
    logic [1:0]  status;
  } grant_t;

  // allocator shadow state
  logic [31:0] sh_base, sh_limit, sh_hdr;
  logic [31:0] sh_start [NCH];
  logic [31:0] sh_len [NCH];
  logic        sh_used [NCH];
  int unsigned sh_count;
  logic [31:0] sh_end;

  request_t    pending_q [$];
  grant_t      grant_q [$];
  logic [31:0] live_q [$];   // addresses handed out, for realistic frees
  int unsigned errors = 0;
  bit          hold_req = 1'b0;

  function automatic logic [31:0] data_addr(int unsigned i);
    return sh_base + sh_start[i] + sh_hdr;
  endfunction

  function automatic void shift_up(int unsigned pos);
    for (int unsigned k = sh_count; k > pos; k--) begin
      sh_start[k] = sh_start[k-1];
      sh_len[k]   = sh_len[k-1];
      sh_used[k]  = sh_used[k-1];
    end
    sh_count++;
  endfunction

  function automatic void shift_down(int unsigned pos);
    for (int unsigned k = pos; k + 1 < sh_count; k++) begin
      sh_start[k] = sh_start[k+1];
      sh_len[k]   = sh_len[k+1];
      sh_used[k]  = sh_used[k+1];
    end
    sh_count--;
  endfunction

  // compute the grant for one request and advance the shadow table
  function automatic grant_t allocate_or_free(request_t r);
    grant_t g;
    logic [63:0] need, rest;
    int unsigned i;
    g.data_address = '0;
    g.status = ffha_pkg::ST_OK;
    if (r.op == ffha_pkg::OP_ALLOC) begin
      need = {32'd0, r.request_size} + {32'd0, sh_hdr};
      for (i = 0; i < sh_count; i++) begin
        if (!sh_used[i] && {32'd0, sh_len[i]} >= need) begin
          rest = {32'd0, sh_len[i]} - need;
          if (rest > {32'd0, sh_hdr} && sh_count < NCH) begin
            shift_up(i + 1);
            sh_start[i+1] = sh_start[i] + need[31:0];
            sh_len[i+1]   = rest[31:0];
            sh_used[i+1]  = 1'b0;
            sh_len[i]     = need[31:0];
          end
          sh_used[i] = 1'b1;
          g.data_address = data_addr(i);
          return g;
        end
      end
      if ({32'd0, sh_end} + need > {32'd0, sh_limit} || sh_count >= NCH) begin
        g.status = ffha_pkg::ST_NO_SPACE;
        return g;
      end
      i = sh_count;
      sh_start[i] = sh_end;
      sh_len[i]   = need[31:0];
      sh_used[i]  = 1'b1;
      sh_count++;
      sh_end += need[31:0];
      g.data_address = data_addr(i);
    end else begin
      for (i = 0; i < sh_count; i++)
        if (sh_used[i] && data_addr(i) == r.free_address) break;
      if (i >= sh_count) begin
        g.status = ffha_pkg::ST_BAD_FREE;
        return g;
      end
      sh_used[i] = 1'b0;
      if (i + 1 < sh_count && !sh_used[i+1]) begin
        sh_len[i] += sh_len[i+1];
        shift_down(i + 1);
      end
      if (i > 0 && !sh_used[i-1]) begin
        sh_len[i-1] += sh_len[i];
        shift_down(i);
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // time limit
  initial begin
    #60ms;
    $display("Mismatches found");
    $finish;
  end

  // accept flag sampled at the rising edge, consumed by the driver
  bit req_taken;
  always @(posedge clk_i) req_taken <= req_if.valid && req_if.ready;

  // request driver: bursts with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_taken) begin
      // hold the word until accepted
    end else begin
      if (req_if.valid) begin
        grant_q.push_back(allocate_or_free(pending_q.pop_front()));
      end
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_q.size() > 0 && !hold_req) begin
        req_if.valid        <= 1'b1;
        req_if.op           <= pending_q[0].op;
        req_if.request_size <= pending_q[0].request_size;
        req_if.free_address <= pending_q[0].free_address;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left--;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response sink: stall pattern of its own
  int unsigned stall_phase = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 29;
      rsp_if.ready <= (stall_phase < 16) || ($urandom_range(0, 3) == 0);
    end
  end

  // monitor
  grant_t want_g;
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected result", rsp_if.data_address, 32'd0);
      end else begin
        want_g = grant_q.pop_front();
        if (rsp_if.data_address !== want_g.data_address)
          report_mismatch("data_address", rsp_if.data_address, want_g.data_address);
        if (rsp_if.status !== want_g.status)
          report_mismatch("status", {30'd0, rsp_if.status}, {30'd0, want_g.status});
        if (want_g.status == ffha_pkg::ST_OK && want_g.data_address != 0)
          live_q.push_back(want_g.data_address);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      ffha_pkg::CFG_HEAP_BASE:   sh_base = val;
      ffha_pkg::CFG_HEAP_LIMIT:  sh_limit = val;
      default:                   sh_hdr = {23'd0, val[8:0]};
    endcase
  endtask

  // wait for every queued word to leave and the block to settle
  task automatic drain();
    while (pending_q.size() > 0 || req_if.valid || grant_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic request_t alloc_req(logic [31:0] sz);
    request_t r;
    r.op = ffha_pkg::OP_ALLOC;
    r.request_size = sz;
    r.free_address = $urandom;
    return r;
  endfunction

  function automatic request_t free_req(logic [31:0] a);
    request_t r;
    r.op = ffha_pkg::OP_FREE;
    r.request_size = $urandom;
    r.free_address = a;
    return r;
  endfunction

  // random phase: mostly small allocs and frees of live blocks
  task automatic random_items(int unsigned n);
    int unsigned pick, idx;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pending_q.push_back(alloc_req($urandom_range(0, 300)));
      end else if (pick < 50) begin
        pending_q.push_back(alloc_req($urandom));
      end else if (pick < 88 && live_q.size() > 0) begin
        idx = $urandom_range(0, live_q.size() - 1);
        pending_q.push_back(free_req(live_q[idx]));
        live_q.delete(idx);
      end else begin
        pending_q.push_back(free_req($urandom));
      end
      if (pending_q.size() > 8) while (pending_q.size() > 2) @(posedge clk_i);
    end
  endtask

  initial begin
    sh_base = 32'd0;
    sh_limit = 32'd1048576;
    sh_hdr = 32'd16;
    sh_count = 0;
    sh_end = 32'd0;
    cfg_if.valid = 1'b0;
    cfg_if.index = ffha_pkg::CFG_HEAP_BASE;
    cfg_if.data = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, split, merge, bad and double free
    pending_q.push_back(alloc_req(32'd0));
    pending_q.push_back(alloc_req(32'd100));
    pending_q.push_back(alloc_req(32'd40));
    pending_q.push_back(alloc_req(32'hFFFF_FFFF));
    pending_q.push_back(free_req(32'd16));
    pending_q.push_back(free_req(32'd16));
    pending_q.push_back(free_req(32'd32));
    pending_q.push_back(free_req(32'hFFFF_FFFF));
    pending_q.push_back(alloc_req(32'd20));
    pending_q.push_back(free_req(32'd164));
    pending_q.push_back(alloc_req(32'd1048576));
    pending_q.push_back(alloc_req(32'd1000));
    drain();

    // fill the table to exercise both table-full cases
    write_reg(ffha_pkg::CFG_HEADER_SIZE, 32'd1);
    write_reg(ffha_pkg::CFG_HEAP_BASE, 32'hFFFF_FF00);
    for (int unsigned k = 0; k < NCH + 2; k++) pending_q.push_back(alloc_req(k[31:0] % 5));
    drain();
    hold_req = 1'b1;
    pending_q.push_back(free_req(32'hFFFF_FF01));
    pending_q.push_back(free_req(32'hFFFF_FF03));
    pending_q.push_back(free_req(32'hFFFF_FF02));
    pending_q.push_back(alloc_req(32'd0));
    hold_req = 1'b0;
    drain();

    // phases over the register settings
    write_reg(ffha_pkg::CFG_HEADER_SIZE, 32'd256);
    write_reg(ffha_pkg::CFG_HEAP_BASE, 32'h0000_1000);
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    random_items(400);
    drain();
    write_reg(ffha_pkg::CFG_HEADER_SIZE, 32'd0);
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd0);
    random_items(150);
    drain();
    write_reg(ffha_pkg::CFG_HEADER_SIZE, 32'd16);
    write_reg(ffha_pkg::CFG_HEAP_BASE, $urandom);
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd1048576);
    random_items(300);
    // pause until every result is in, then carry on
    hold_req = 1'b1;
    while (req_if.valid || grant_q.size() > 0) @(posedge clk_i);
    hold_req = 1'b0;
    random_items(300);
    drain();
    write_reg(ffha_pkg::CFG_HEADER_SIZE, 32'h1FF);
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, sh_end + 32'd5000);
    random_items(400);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
src/ffha_pkg.sv
src/ffha_if.sv
src/ffha_cell.sv
src/ffha_chain.sv
src/first_fit_heap_allocator.sv
bench/tb_first_fit_heap_allocator.sv
